/* src/ckbs_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package ckbs_pkg;

	localparam int MAX_WIDTH = 1024;
	localparam int ADDR_W    = $clog2(MAX_WIDTH);
	localparam int WIDTH_W   = 11;
	localparam int HEIGHT_W  = 12;
	localparam int CHAN_W    = 8;
	localparam int PIX_W     = 3 * CHAN_W;
	localparam int CFG_W     = HEIGHT_W;

	localparam logic [WIDTH_W-1:0]  DEF_WIDTH  = WIDTH_W'(640);
	localparam logic [HEIGHT_W-1:0] DEF_HEIGHT = HEIGHT_W'(480);
	localparam logic [WIDTH_W-1:0]  MAX_W_VAL  = WIDTH_W'(MAX_WIDTH);

	typedef logic [PIX_W-1:0] pix_t;

	typedef enum logic {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} reg_idx_t;

	typedef enum logic {
		OP_PIXEL = 1'b0,
		OP_FLUSH = 1'b1
	} op_t;

	// per channel (a + b + c + d) / 4, truncated
	function automatic pix_t mean4(input pix_t a, input pix_t b, input pix_t c, input pix_t d);
		logic [CHAN_W+1:0] sum;
		pix_t              res;
		res = '0;
		for (int i = 0; i < 3; i++) begin
			sum = {2'b00, a[i*CHAN_W +: CHAN_W]} + {2'b00, b[i*CHAN_W +: CHAN_W]}
				+ {2'b00, c[i*CHAN_W +: CHAN_W]} + {2'b00, d[i*CHAN_W +: CHAN_W]};
			res[i*CHAN_W +: CHAN_W] = sum[CHAN_W+1:2];
		end
		return res;
	endfunction

endpackage

`default_nettype wire

/* src/ckbs_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module ckbs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr_a,
	output logic      [WIDTH-1:0] rdata_a,
	input  wire logic [AW-1:0]    raddr_b,
	output logic      [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

`default_nettype wire

/* src/cross_kernel_blur_stream_top.sv */
`timescale 1ns / 1ps
`default_nettype none

// Four-neighbour mean blur for RGB888 pixels streamed in raster order.
// s_axis carries one pixel per transfer (tdata) and a flush mark (tuser).
// m_axis carries the blurred pixel (tdata) and tlast on the last pixel of a frame.
// The cfg port sets image_width (index 0) and image_height (index 1); write it only
// while the stream is idle.
// Output lags input by one image line: the result for row r comes out while row r+1
// goes in. The first row gives no results. After the last row, one transfer per
// pixel (flush or pixel, data ignored) drains the final row; flushes sent inside a
// frame are dropped.
// Throughput is one pixel per cycle while m_axis takes results. Each pixel passes the
// read of the shared line store (rows above, at columns x and x+1), then the sum and
// the output register. The line store write of a pixel overlaps the read of the next
// one and is forwarded to it where both address the same entry.
// Reset clears the counters and the output valid flag, sets 640 x 480 and leaves the
// line store contents undefined; no clearing pass is needed.
// When m_axis stalls, the output register holds its result; s_axis keeps taking pixels
// until the read stage holds one that has a result, then tready drops.
module cross_kernel_blur_stream_top (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic                           cfg_addr,
	input  wire logic [ckbs_pkg::CFG_W-1:0]     cfg_data,
	input  wire logic                           s_axis_tvalid,
	output logic                                s_axis_tready,
	input  wire logic [ckbs_pkg::PIX_W-1:0]     s_axis_tdata,  // red, green, blue
	input  wire logic                           s_axis_tuser,  // operation
	output logic                                m_axis_tvalid,
	input  wire logic                           m_axis_tready,
	output logic      [ckbs_pkg::PIX_W-1:0]     m_axis_tdata,  // red, green, blue
	output logic                                m_axis_tlast
);

	localparam int AW = ckbs_pkg::ADDR_W;
	localparam int WW = ckbs_pkg::WIDTH_W;
	localparam int HW = ckbs_pkg::HEIGHT_W;

	logic [WW-1:0] width_q;
	logic [HW-1:0] height_q;
	logic [AW-1:0] col_q;
	logic [HW-1:0] row_q;

	logic [WW-1:0] w_eff;
	logic [HW-1:0] h_eff;
	logic [AW-1:0] x;
	logic [AW-1:0] x_plus;
	logic [HW-1:0] y;
	logic          flushing;
	logic          last_col;
	logic          item_ok;
	logic          accept;

	logic                   valid_s1;
	logic                   res_s1;
	logic                   flush_s1;
	logic                   fend_s1;
	logic [AW-1:0]          x_s1;
	logic                   left_ok_s1;
	logic                   right_ok_s1;
	logic                   above_ok_s1;
	ckbs_pkg::pix_t         below_s1;
	logic                   fwd_a_s1;
	logic                   fwd_b_s1;
	logic [2*ckbs_pkg::PIX_W-1:0] fwd_q;
	ckbs_pkg::pix_t         left_q;

	logic [2*ckbs_pkg::PIX_W-1:0] rd_a;
	logic [2*ckbs_pkg::PIX_W-1:0] rd_b;
	logic [2*ckbs_pkg::PIX_W-1:0] line_a;
	logic [2*ckbs_pkg::PIX_W-1:0] wdata;
	ckbs_pkg::pix_t         center;
	ckbs_pkg::pix_t         above;
	ckbs_pkg::pix_t         right;
	ckbs_pkg::pix_t         left;
	ckbs_pkg::pix_t         mid_b;

	logic out_free;
	logic s1_adv;
	logic wr;

	// effective geometry and position of the incoming transfer
	always_comb begin
		if (width_q == '0) begin
			w_eff = WW'(1);
		end else if (width_q > ckbs_pkg::MAX_W_VAL) begin
			w_eff = ckbs_pkg::MAX_W_VAL;
		end else begin
			w_eff = width_q;
		end
		h_eff    = (height_q == '0) ? HW'(1) : height_q;
		x        = ({1'b0, col_q} >= w_eff) ? '0 : col_q;
		y        = (row_q > h_eff) ? h_eff : row_q;
		x_plus   = x + AW'(1);
		flushing = (y == h_eff);
		last_col = (({1'b0, x} + WW'(1)) >= w_eff);
		item_ok  = !((s_axis_tuser == ckbs_pkg::OP_FLUSH) && !flushing);
	end

	assign out_free      = !m_axis_tvalid || m_axis_tready;
	assign s1_adv        = !valid_s1 || !res_s1 || out_free;
	assign s_axis_tready = s1_adv;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign wr            = valid_s1 && s1_adv;

	// line store entry: upper row in the high half, middle row in the low half
	always_comb begin
		line_a = fwd_a_s1 ? fwd_q : rd_a;
		mid_b  = fwd_b_s1 ? fwd_q[ckbs_pkg::PIX_W-1:0] : rd_b[ckbs_pkg::PIX_W-1:0];
		center = line_a[ckbs_pkg::PIX_W-1:0];
		above  = above_ok_s1 ? line_a[2*ckbs_pkg::PIX_W-1:ckbs_pkg::PIX_W] : '0;
		right  = right_ok_s1 ? mid_b : '0;
		left   = left_ok_s1 ? left_q : '0;
		wdata  = {center, (flush_s1 ? center : below_s1)};
	end

	ckbs_ram #(
		.WIDTH(2 * ckbs_pkg::PIX_W),
		.DEPTH(ckbs_pkg::MAX_WIDTH)
	) u_line (
		.clk    (clk),
		.we     (wr),
		.waddr  (x_s1),
		.wdata  (wdata),
		.re     (accept),
		.raddr_a(x),
		.rdata_a(rd_a),
		.raddr_b(x_plus),
		.rdata_b(rd_b)
	);

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= ckbs_pkg::DEF_WIDTH;
			height_q <= ckbs_pkg::DEF_HEIGHT;
		end else if (cfg_we) begin
			case (cfg_addr)
				ckbs_pkg::REG_IMAGE_WIDTH:  width_q  <= cfg_data[WW-1:0];
				ckbs_pkg::REG_IMAGE_HEIGHT: height_q <= cfg_data[HW-1:0];
				default: ;
			endcase
		end
	end

	// position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (!item_ok) begin
				col_q <= x;
				row_q <= y;
			end else if (!last_col) begin
				col_q <= x_plus;
				row_q <= y;
			end else begin
				col_q <= '0;
				row_q <= flushing ? '0 : y + HW'(1);
			end
		end
	end

	// read stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			res_s1   <= 1'b0;
		end else if (s1_adv) begin
			valid_s1 <= accept && item_ok;
			res_s1   <= (y != '0);
		end
	end

	// read stage payload and store forwarding
	always_ff @(posedge clk) begin
		if (accept) begin
			flush_s1    <= flushing;
			fend_s1     <= flushing && last_col;
			x_s1        <= x;
			left_ok_s1  <= (x != '0);
			right_ok_s1 <= !last_col;
			above_ok_s1 <= (y >= HW'(2));
			below_s1    <= flushing ? '0 : s_axis_tdata;
			fwd_a_s1    <= wr && (x_s1 == x);
			fwd_b_s1    <= wr && (x_s1 == x_plus);
			fwd_q       <= wdata;
		end
		if (wr) begin
			left_q <= center;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (out_free) begin
			m_axis_tvalid <= valid_s1 && res_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s1 && res_s1) begin
			m_axis_tdata <= ckbs_pkg::mean4(above, below_s1, left, right);
			m_axis_tlast <= fend_s1;
		end
	end

endmodule

`default_nettype wire

/* tb/sv/cross_kernel_blur_stream_top_tb.sv */
`timescale 1ns / 1ps

module cross_kernel_blur_stream_top_tb;
	import ckbs_pkg::*;

	localparam int CYCLE_LIMIT = 600000;
	localparam int RANDOM_ITEMS = 200;

	typedef struct packed {
		op_t  op;
		pix_t pix;
	} stim_t;

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
		logic              frame_end;
	} blur_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_we = 1'b0;
	logic                cfg_addr = REG_IMAGE_WIDTH;
	logic [CFG_W-1:0]    cfg_data = '0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [PIX_W-1:0]    s_axis_tdata = '0;  // red, green, blue
	logic                s_axis_tuser = OP_PIXEL;  // operation
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [PIX_W-1:0]    m_axis_tdata;  // red, green, blue
	logic                m_axis_tlast;

	// blur predictor state
	pix_t                upper_row [0:MAX_WIDTH-1];
	pix_t                mid_row [0:MAX_WIDTH-1];
	pix_t                prev_center = '0;
	int                  col_cnt = 0;
	int                  row_cnt = 0;
	logic [WIDTH_W-1:0]  cfg_w = DEF_WIDTH;
	logic [HEIGHT_W-1:0] cfg_h = DEF_HEIGHT;

	stim_t               pixel_feed [$];
	blur_t               blurred_q [$];
	stim_t               nxt;
	blur_t               want;
	bit                  quiet = 1'b0;
	bit                  long_done = 1'b0;
	int                  tx_gap = 0;
	int                  rx_gap = 0;
	int                  long_hold = 0;
	int                  items_accepted = 0;
	int                  results_seen = 0;
	int                  frames_seen = 0;
	int                  err_count = 0;
	int                  stim_count = 0;
	int                  cycles = 0;
	int                  w_rand;
	int                  h_rand;
	int                  k_rows;

	cross_kernel_blur_stream_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #4 clk = ~clk;

	function automatic logic [CHAN_W-1:0] mean_chan(input pix_t a, input pix_t b, input pix_t c,
			input pix_t d, input int ch);
		logic [CHAN_W+1:0] sum;
		sum = {2'b00, a[ch*CHAN_W +: CHAN_W]} + {2'b00, b[ch*CHAN_W +: CHAN_W]}
			+ {2'b00, c[ch*CHAN_W +: CHAN_W]} + {2'b00, d[ch*CHAN_W +: CHAN_W]};
		return sum[CHAN_W+1:2];
	endfunction

	// one accepted transfer through the blur, pushes the blurred pixel it releases
	function automatic void advance_blur(input op_t op, input pix_t pin);
		int    w;
		int    h;
		int    x;
		int    y;
		bit    flushing;
		pix_t  below;
		pix_t  above;
		pix_t  center;
		pix_t  left;
		pix_t  right;
		blur_t res;
		w = cfg_w;
		h = cfg_h;
		if (w < 1) w = 1;
		if (w > MAX_WIDTH) w = MAX_WIDTH;
		if (h < 1) h = 1;
		if (col_cnt >= w) col_cnt = 0;
		if (row_cnt > h) row_cnt = h;
		x = col_cnt;
		y = row_cnt;
		flushing = (y == h);
		if (op == OP_FLUSH && !flushing) return;
		below = flushing ? '0 : pin;
		above = (y >= 2) ? upper_row[x] : '0;
		center = mid_row[x];
		left = (x == 0) ? '0 : prev_center;
		right = (x + 1 < w) ? mid_row[x + 1] : '0;
		upper_row[x] = center;
		if (!flushing) mid_row[x] = below;
		prev_center = center;
		if (x + 1 < w) begin
			col_cnt = x + 1;
		end else begin
			col_cnt = 0;
			row_cnt = flushing ? 0 : y + 1;
		end
		if (y == 0) return;
		res.red = mean_chan(above, below, left, right, 0);
		res.green = mean_chan(above, below, left, right, 1);
		res.blue = mean_chan(above, below, left, right, 2);
		res.frame_end = flushing && (x + 1 >= w);
		blurred_q.push_back(res);
	endfunction

	function automatic logic [CHAN_W-1:0] rand_chan();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return CHAN_W'($urandom);
		endcase
	endfunction

	function automatic pix_t rand_pix();
		return {rand_chan(), rand_chan(), rand_chan()};
	endfunction

	function automatic void add_item(input op_t op, input pix_t pix);
		stim_t s;
		s.op = op;
		s.pix = pix;
		pixel_feed.push_back(s);
	endfunction

	// full rows of pixels, with the odd flush dropped inside the frame
	function automatic void push_rows(input int w, input int nrows);
		for (int r = 0; r < nrows; r++) begin
			for (int c = 0; c < w; c++) begin
				if ($urandom_range(0, 15) == 0) add_item(OP_FLUSH, rand_pix());
				add_item(OP_PIXEL, rand_pix());
				stim_count++;
			end
		end
	endfunction

	// one row of drain transfers, flush or pixel
	function automatic void push_drain(input int w);
		for (int c = 0; c < w; c++) begin
			add_item($urandom_range(0, 1) ? OP_FLUSH : OP_PIXEL, rand_pix());
			stim_count++;
		end
	endfunction

	task automatic write_reg(input reg_idx_t idx, input int val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= CFG_W'(val);
		if (idx == REG_IMAGE_WIDTH) cfg_w = WIDTH_W'(val);
		else cfg_h = HEIGHT_W'(val);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_size(input int w, input int h);
		write_reg(REG_IMAGE_WIDTH, w);
		write_reg(REG_IMAGE_HEIGHT, h);
	endtask

	task automatic wait_idle();
		do @(negedge clk);
		while (pixel_feed.size() != 0 || s_axis_tvalid || blurred_q.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	function automatic void flag_error(input string msg);
		err_count++;
		if (err_count <= 10) $display("ERROR at %0t: %s", $realtime, msg);
	endfunction

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			tx_gap = 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				advance_blur(op_t'(s_axis_tuser), s_axis_tdata);
				items_accepted++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (tx_gap > 0) begin
					tx_gap--;
					s_axis_tvalid <= 1'b0;
				end else if (pixel_feed.size() != 0 && !quiet && $urandom_range(0, 9) == 0) begin
					tx_gap = $urandom_range(1, 18) - 1;
					s_axis_tvalid <= 1'b0;
				end else if (pixel_feed.size() != 0) begin
					nxt = pixel_feed.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= nxt.pix;
					s_axis_tuser <= nxt.op;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver ready, with one long hold-off to back the block up
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (long_hold > 0) begin
			long_hold--;
			m_axis_tready <= 1'b0;
		end else if (!long_done && !quiet && results_seen >= 120) begin
			long_done = 1'b1;
			long_hold = 299;
			m_axis_tready <= 1'b0;
		end else if (rx_gap > 0) begin
			rx_gap--;
			m_axis_tready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 11) == 0) begin
			rx_gap = $urandom_range(1, 18) - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// result checker
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			results_seen++;
			if (m_axis_tlast) frames_seen++;
			if (blurred_q.size() == 0) begin
				flag_error($sformatf("unexpected transfer data=%06h last=%0b",
					m_axis_tdata, m_axis_tlast));
			end else begin
				want = blurred_q.pop_front();
				if (m_axis_tdata[0 +: CHAN_W] !== want.red
						|| m_axis_tdata[CHAN_W +: CHAN_W] !== want.green
						|| m_axis_tdata[2*CHAN_W +: CHAN_W] !== want.blue
						|| m_axis_tlast !== want.frame_end)
					flag_error($sformatf(
						"result %0d exp r=%02h g=%02h b=%02h last=%0b got r=%02h g=%02h b=%02h last=%0b",
						results_seen, want.red, want.green, want.blue, want.frame_end,
						m_axis_tdata[0 +: CHAN_W], m_axis_tdata[CHAN_W +: CHAN_W],
						m_axis_tdata[2*CHAN_W +: CHAN_W], m_axis_tlast));
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles, blurred_q.size());
			$display("cross_kernel_blur_stream_top_tb: FAIL");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < MAX_WIDTH; i++) begin
			upper_row[i] = '0;
			mid_row[i] = '0;
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// 3x3 frame: corners, edges, saturated and zero pixels, stray flushes
		set_size(3, 3);
		add_item(OP_FLUSH, '1);
		add_item(OP_PIXEL, 24'h000000);
		add_item(OP_PIXEL, 24'hffffff);
		add_item(OP_PIXEL, 24'hff00ff);
		add_item(OP_FLUSH, 24'haaaaaa);
		add_item(OP_PIXEL, 24'h00ff00);
		add_item(OP_PIXEL, 24'hffffff);
		add_item(OP_PIXEL, 24'h000000);
		add_item(OP_PIXEL, 24'hffffff);
		add_item(OP_PIXEL, 24'hffffff);
		add_item(OP_PIXEL, 24'h000000);
		add_item(OP_FLUSH, 24'h000000);
		add_item(OP_PIXEL, 24'hffffff);
		add_item(OP_FLUSH, 24'h555555);
		wait_idle();

		// single pixel frame
		set_size(1, 1);
		add_item(OP_PIXEL, 24'hffffff);
		add_item(OP_PIXEL, 24'h123456);
		wait_idle();

		// widest row, then drained at a narrower width
		set_size(MAX_WIDTH, 1);
		push_rows(MAX_WIDTH, 1);
		wait_idle();
		write_reg(REG_IMAGE_WIDTH, 6);
		push_drain(6);
		wait_idle();

		// tallest frame, cut short by lowering the height mid frame
		set_size(2, 4095);
		push_rows(2, 12);
		wait_idle();
		write_reg(REG_IMAGE_HEIGHT, 5);
		push_drain(2);
		wait_idle();

		// narrowing mid row restarts the row at column 0
		set_size(9, 6);
		push_rows(9, 3);
		for (int c = 0; c < 6; c++) add_item(OP_PIXEL, rand_pix());
		wait_idle();
		write_reg(REG_IMAGE_WIDTH, 4);
		push_rows(4, 3);
		push_drain(4);
		wait_idle();

		stim_count = 0;
		while (stim_count < RANDOM_ITEMS) begin
			if ($urandom_range(0, 3) == 0) begin
				w_rand = $urandom_range(25, 48);
				h_rand = $urandom_range(1, 2);
			end else begin
				w_rand = $urandom_range(1, 24);
				h_rand = $urandom_range(1, 4);
			end
			set_size(w_rand, h_rand);
			if (h_rand >= 2 && $urandom_range(0, 5) == 0) begin
				k_rows = $urandom_range(1, h_rand - 1);
				push_rows(w_rand, k_rows);
				wait_idle();
				write_reg(REG_IMAGE_HEIGHT, $urandom_range(1, k_rows));
			end else begin
				push_rows(w_rand, h_rand);
			end
			push_drain(w_rand);
			wait_idle();
		end

		// closing frame at full rate
		quiet = 1'b1;
		set_size(7, 4);
		push_rows(7, 4);
		push_drain(7);
		wait_idle();
		repeat (8) @(negedge clk);

		$display("%0d transfers in, %0d blurred pixels checked, %0d frame ends seen",
			items_accepted, results_seen, frames_seen);
		$display("sizes from 1x1 to 1024 wide and 4095 high, resizes mid frame, %0d errors",
			err_count);
		if (err_count == 0 && blurred_q.size() == 0) begin
			$display("cross_kernel_blur_stream_top_tb: PASS");
		end else begin
			$display("cross_kernel_blur_stream_top_tb: FAIL");
		end
		$finish;
	end

endmodule
